### rtl/core/xxh64_stream_hash_top_assert.svh
// Assertion macros for the checker file.
`ifndef XXH64_STREAM_HASH_TOP_ASSERT_SVH
`define XXH64_STREAM_HASH_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define XXH_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define XXH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

### rtl/core/xxh_pkg.sv
// ----------------------------------------------------------------------------
// xxh_pkg
// Constants, types and helper functions of the XXH64 stream hash.
// ----------------------------------------------------------------------------
package xxh_pkg;
   localparam logic [63:0] PRIME_1 = 64'd11400714785074694791;
   localparam logic [63:0] PRIME_2 = 64'd14029467366897019727;
   localparam logic [63:0] PRIME_3 = 64'd1609587929392839161;
   localparam logic [63:0] PRIME_4 = 64'd9650029242287828579;
   localparam logic [63:0] PRIME_5 = 64'd2870177450012600261;
   localparam int unsigned NUM_LANES = 4;

   typedef struct packed {
      logic [63:0] word0;
      logic [63:0] word1;
      logic [63:0] word2;
      logic [63:0] word3;
      logic [5:0]  byte_count;
      logic        first;
      logic        last;
      logic [63:0] seed;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] hash;
   } rsp_payload_type;

   // Handshake between the top-level sequencer and the lane bank.
   typedef struct packed {
      logic start;
      logic load_seed;
      logic [63:0] seed;
   } lane_ctrl_type;

   // Partial products of the low half of a 64x64 product.
   typedef struct packed {
      logic [63:0] lo_lo;
      logic [31:0] lo_hi;
      logic [31:0] hi_lo;
   } mul_parts_type;

   function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] n);
      logic [127:0] d;
      d = {v, v} << n;
      return d[127:64];
   endfunction

   // First half of a 64-bit product: three 32x32 multiplies.
   function automatic mul_parts_type mul_split(input logic [63:0] a, input logic [63:0] b);
      mul_parts_type p;
      p.lo_lo = 64'(a[31:0]) * 64'(b[31:0]);
      p.lo_hi = a[31:0] * b[63:32];
      p.hi_lo = a[63:32] * b[31:0];
      return p;
   endfunction

   // Second half: the cross terms only reach the upper word.
   function automatic logic [63:0] mul_join(input mul_parts_type p);
      return p.lo_lo + {p.lo_hi + p.hi_lo, 32'd0};
   endfunction
endpackage

### rtl/core/xxh_if.sv
// ----------------------------------------------------------------------------
// xxh_req_if / xxh_rsp_if
// Valid/ready channels that carry requests and hash results.
// ----------------------------------------------------------------------------
interface xxh_req_if import xxh_pkg::*; ();
   logic valid;
   logic ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface xxh_rsp_if import xxh_pkg::*; ();
   logic valid;
   logic ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/core/xxh_lane.sv
// ----------------------------------------------------------------------------
// xxh_lane
// One lane accumulator: a round is add of w*P2, rotate 31, multiply by P1.
// Each product's 32x32 partial products are registered and summed in the
// next cycle, first for the word product, then for the rotated sum.
// ----------------------------------------------------------------------------
module xxh_lane import xxh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        load,
   input  logic [63:0] load_value,
   input  logic [63:0] word,
   output logic [63:0] acc,
   output logic        done
);
   logic [63:0]   acc_ff, acc_in;
   logic [63:0]   prod_ff, prod_in;
   logic [1:0]    step_ff, step_in;
   mul_parts_type parts_ff, parts_in;
   logic [63:0]   mul_a, mul_b;

   // The word is taken straight from the request, so the first partial
   // products are captured on the accepting edge.
   assign mul_a = (step_ff == 2'd0) ? word : rotl(acc_ff + prod_ff, 6'd31);
   assign mul_b = (step_ff == 2'd0) ? PRIME_2 : PRIME_1;
   assign parts_in = mul_split(mul_a, mul_b);

   always_comb begin
      acc_in  = acc_ff;
      prod_in = prod_ff;
      step_in = step_ff;
      if (load) begin
         acc_in = load_value;
      end
      unique case (step_ff)
         2'd0: if (start) step_in = 2'd1;
         2'd1: begin
            prod_in = mul_join(parts_ff);
            step_in = 2'd2;
         end
         2'd2: step_in = 2'd3;
         2'd3: begin
            acc_in  = mul_join(parts_ff);
            step_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      parts_ff <= parts_in;
      if (reset) begin
         acc_ff  <= '0;
         step_ff <= 2'd0;
      end else begin
         acc_ff  <= acc_in;
         step_ff <= step_in;
      end
   end

   assign acc  = acc_ff;
   assign done = (step_ff == 2'd3);
endmodule

### rtl/core/xxh_finish.sv
// ----------------------------------------------------------------------------
// xxh_finish
// Merging and finalization sequencer: combines the lanes on merge, folds
// the tail one step at a time and applies the avalanche. Every multiply
// is split: registered partial products first, their sum second.
// ----------------------------------------------------------------------------
module xxh_finish import xxh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        merge,
   input  logic [63:0] seed,
   input  logic [63:0] total,
   input  logic [255:0] lanes,
   input  logic [255:0] words,
   input  logic [5:0]  count,
   output logic        busy,
   output logic        done,
   output logic [63:0] hash
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MRG   = 4'd1;  // lane fold: a*P2
   localparam logic [3:0] S_MRG2  = 4'd2;  // rot31 * P1
   localparam logic [3:0] S_MRG3  = 4'd3;  // (h^r)*P1 + P4
   localparam logic [3:0] S_LEN   = 4'd4;
   localparam logic [3:0] S_W1    = 4'd5;  // word: w*P2
   localparam logic [3:0] S_W2    = 4'd6;  // rot31*P1
   localparam logic [3:0] S_W3    = 4'd7;  // rot27(h^r)*P1+P4
   localparam logic [3:0] S_PC    = 4'd8;  // piece*P1
   localparam logic [3:0] S_PC2   = 4'd9;  // rot23(h^r)*P2+P3
   localparam logic [3:0] S_BY    = 4'd10; // byte*P5
   localparam logic [3:0] S_BY2   = 4'd11; // rot11(h^r)*P1
   localparam logic [3:0] S_AV1   = 4'd12;
   localparam logic [3:0] S_AV2   = 4'd13;
   localparam logic [3:0] S_OUT   = 4'd14;

   logic [3:0]  state_ff, state_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] t_ff, t_in;
   logic [5:0]  j_ff, j_in;
   logic [1:0]  li_ff, li_in;
   logic        done_ff, done_in;
   logic        ph_ff, ph_in;
   logic        is_mul;
   mul_parts_type parts_ff, parts_in;
   logic [63:0] ma, mb, mp;
   logic [63:0] cur_word, cur_lane;
   logic [7:0]  cur_byte;
   logic [6:0]  j8, j4;

   assign cur_word = words[{j_ff[4:3], 6'd0} +: 64];
   assign cur_lane = lanes[{li_ff, 6'd0} +: 64];
   assign cur_byte = words[{j_ff[4:0], 3'd0} +: 8];
   assign j8 = {1'b0, j_ff} + 7'd8;
   assign j4 = {1'b0, j_ff} + 7'd4;

   // Every state but idle, length and output runs one multiply.
   assign is_mul = (state_ff != S_IDLE) && (state_ff != S_LEN) && (state_ff != S_OUT);

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (state_ff)
         S_MRG:  begin ma = cur_lane; mb = PRIME_2; end
         S_MRG2, S_W2: begin ma = rotl(t_ff, 6'd31); mb = PRIME_1; end
         S_MRG3: begin ma = h_ff ^ t_ff; mb = PRIME_1; end
         S_W1:   begin ma = cur_word; mb = PRIME_2; end
         S_W3:   begin ma = rotl(h_ff ^ t_ff, 6'd27); mb = PRIME_1; end
         S_PC:   begin ma = {32'd0, cur_word[31:0]}; mb = PRIME_1; end
         S_PC2:  begin ma = rotl(h_ff ^ t_ff, 6'd23); mb = PRIME_2; end
         S_BY:   begin ma = {56'd0, cur_byte}; mb = PRIME_5; end
         S_BY2:  begin ma = rotl(h_ff ^ t_ff, 6'd11); mb = PRIME_1; end
         S_AV1:  begin ma = h_ff ^ (h_ff >> 33); mb = PRIME_2; end
         S_AV2:  begin ma = h_ff ^ (h_ff >> 29); mb = PRIME_3; end
         default: begin ma = '0; mb = '0; end
      endcase
   end
   assign parts_in = mul_split(ma, mb);
   assign mp = mul_join(parts_ff);

   always_comb begin
      state_in = state_ff;
      h_in = h_ff;
      t_in = t_ff;
      j_in = j_ff;
      li_in = li_ff;
      done_in = 1'b0;
      ph_in = 1'b0;
      if (is_mul && !ph_ff) begin
         // Partial products are captured; the operands stay put meanwhile.
         ph_in = 1'b1;
      end else begin
         unique case (state_ff)
            S_IDLE: if (start) begin
               j_in = '0;
               li_in = '0;
               if (merge) begin
                  h_in = rotl(lanes[63:0], 6'd1) + rotl(lanes[127:64], 6'd7)
                       + rotl(lanes[191:128], 6'd12) + rotl(lanes[255:192], 6'd18);
                  state_in = S_MRG;
               end else begin
                  h_in = seed + PRIME_5;
                  state_in = S_LEN;
               end
            end
            S_MRG: begin t_in = mp; state_in = S_MRG2; end
            S_MRG2: begin t_in = mp; state_in = S_MRG3; end
            S_MRG3: begin
               h_in = mp + PRIME_4;
               li_in = li_ff + 2'd1;
               state_in = (li_ff == 2'd3) ? S_LEN : S_MRG;
            end
            S_LEN: begin
               h_in = h_ff + total;
               if (j8 <= {1'b0, count}) state_in = S_W1;
               else if (j4 <= {1'b0, count}) state_in = S_PC;
               else if (j_ff < count) state_in = S_BY;
               else state_in = S_AV1;
            end
            S_W1: begin t_in = mp; state_in = S_W2; end
            S_W2: begin t_in = mp; state_in = S_W3; end
            S_W3: begin
               j_in = j8[5:0];
               state_in = S_LEN;
               h_in = mp + PRIME_4 - total;
            end
            S_PC: begin t_in = mp; state_in = S_PC2; end
            S_PC2: begin
               h_in = mp + PRIME_3 - total;
               j_in = j4[5:0];
               state_in = S_LEN;
            end
            S_BY: begin t_in = mp; state_in = S_BY2; end
            S_BY2: begin
               h_in = mp - total;
               j_in = j_ff + 6'd1;
               state_in = S_LEN;
            end
            S_AV1: begin h_in = mp; state_in = S_AV2; end
            S_AV2: begin
               h_in = mp ^ (mp >> 32);
               state_in = S_OUT;
               done_in = 1'b1;
            end
            S_OUT: state_in = S_IDLE;
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      t_ff <= t_in;
      j_ff <= j_in;
      li_ff <= li_in;
      parts_ff <= parts_in;
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
         ph_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
         ph_ff <= ph_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign done = done_ff;
   assign hash = h_ff;
endmodule

### rtl/core/xxh64_stream_hash_top.sv
// ----------------------------------------------------------------------------
// xxh64_stream_hash_top
// Streaming XXH64 hash over 32-byte stripes with four parallel lanes.
// ----------------------------------------------------------------------------
// A message is sent as requests of one 32-byte stripe (four little-endian
// words); the first request carries the seed and the last one carries 0 to 32
// valid bytes and produces one 64-bit hash. For a full stripe the four lane
// units each run a multiply, rotate, multiply round, and every 64-bit
// multiply is split into 32x32 partial products, which are registered, and
// their sum. The last request then runs the merging sequencer, which owns
// one such split multiplier: it folds in each lane if the lanes ran, then
// adds the length and folds each tail word, a 4-byte piece and each tail
// byte, and ends with the avalanche and output. One request is worked on
// at a time: no new request is taken until the current one is through.
// The result register holds the hash until taken while the next message
// may already begin; only the finalization of the following last request
// waits until that register is free.
module xxh64_stream_hash_top import xxh_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   xxh_req_if.sink  req,
   xxh_rsp_if.source rsp
);
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LANES  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]   state_ff, state_in;
   logic [63:0]  seed_ff, seed_in;
   logic [63:0]  total_ff, total_in;
   logic         seen_ff, seen_in;
   logic [255:0] words_ff;
   logic [255:0] req_words;
   logic [5:0]   count_ff;
   logic         last_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  rsp_hash_ff;
   logic         accept;
   lane_ctrl_type ctrl;
   logic [255:0] lane_acc;
   logic [NUM_LANES-1:0] lane_done;
   logic         fin_start, fin_busy, fin_done;
   logic [63:0]  fin_hash;
   logic         full_last;

   // A new request may enter whenever the block is idle; a held result does
   // not block it.
   assign req.ready = (state_ff == ST_IDLE);
   assign accept = req.valid && req.ready;
   assign full_last = (req.data.byte_count >= 6'd32);
   assign req_words = {req.data.word3, req.data.word2, req.data.word1, req.data.word0};

   // Lane control: seed load and round start happen on acceptance.
   assign ctrl.load_seed = accept && req.data.first;
   assign ctrl.seed = req.data.seed;
   assign ctrl.start = accept && (!req.data.last || full_last);

   genvar g;
   generate
      for (g = 0; g < NUM_LANES; g++) begin : g_lane
         logic [63:0] init_v;
         always_comb begin
            unique case (g)
               0: init_v = ctrl.seed + PRIME_1 + PRIME_2;
               1: init_v = ctrl.seed + PRIME_2;
               2: init_v = ctrl.seed;
               default: init_v = ctrl.seed - PRIME_1;
            endcase
         end
         // The lanes see the request words directly so that their first
         // partial products form on the accepting cycle.
         xxh_lane u_lane (
            .clock(clock), .reset(reset), .start(ctrl.start),
            .load(ctrl.load_seed), .load_value(init_v),
            .word(req_words[g*64 +: 64]), .acc(lane_acc[g*64 +: 64]),
            .done(lane_done[g])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      seed_in = seed_ff;
      total_in = total_ff;
      seen_in = seen_ff;
      fin_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            if (req.data.first) begin
               seed_in = req.data.seed;
               total_in = '0;
               seen_in = 1'b0;
            end
            if (!req.data.last || full_last) begin
               total_in = (req.data.first ? 64'd0 : total_ff) + 64'd32;
               seen_in = 1'b1;
               state_in = ST_LANES;
            end else begin
               total_in = (req.data.first ? 64'd0 : total_ff)
                        + {58'd0, req.data.byte_count};
               state_in = ST_FINISH;
            end
         end
         // The lanes finish together; the state moves on as their
         // accumulators take the new value.
         ST_LANES: if (&lane_done) begin
            state_in = last_ff ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            // The sequencer is started once, as soon as the result register
            // is free or is being emptied in this cycle.
            fin_start = !fin_busy && !fin_done && (!rsp_valid_ff || rsp.ready);
            if (fin_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   xxh_finish u_finish (
      .clock(clock), .reset(reset), .start(fin_start), .merge(seen_ff),
      .seed(seed_ff), .total(total_ff), .lanes(lane_acc), .words(words_ff),
      .count(count_ff), .busy(fin_busy), .done(fin_done), .hash(fin_hash)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      if (fin_done) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         words_ff <= req_words;
         count_ff <= full_last ? 6'd0 : req.data.byte_count;
         last_ff  <= req.data.last;
      end
      if (fin_done) rsp_hash_ff <= fin_hash;
      if (reset) begin
         state_ff <= ST_IDLE;
         seed_ff <= '0;
         total_ff <= '0;
         seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seed_ff <= seed_in;
         total_ff <= total_in;
         seen_ff <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data.hash = rsp_hash_ff;
endmodule

### rtl/core/xxh_checker.sv
// ----------------------------------------------------------------------------
// xxh_checker
// Port-level checks of the stream hash, bound to the top level.
// ----------------------------------------------------------------------------
`include "xxh64_stream_hash_top_assert.svh"
module xxh_checker import xxh_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [63:0] rsp_hash
);
   `XXH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hash), "rsp dropped or changed while stalled")
   `XXH_ASSERT_NEXT(a_busy_after, req_valid && req_ready, !req_ready, "request taken on back-to-back cycles")
   `XXH_ASSERT_NEXT(a_no_early_rsp, req_valid && req_ready && req_last, !rsp_valid || $past(rsp_valid), "hash appeared with no work")
endmodule

bind xxh64_stream_hash_top xxh_checker u_xxh_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .req_last(req.data.last), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_hash(rsp.data.hash)
);
